@@ design/dedc_pkg.sv @@
package dedc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 10;

   localparam int STEP_WIDTH  = 4;
   localparam int LIMIT_WIDTH = 10;
   localparam int OUT_COUNT_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 16;

   localparam logic [1:0] REST_PHASE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_STEP  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_STEP   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_LIMIT = 2'd2;

   localparam logic [STEP_WIDTH-1:0]  RIGHT_STEP_RESET  = 4'd1;
   localparam logic [STEP_WIDTH-1:0]  LEFT_STEP_RESET   = 4'd2;
   localparam logic [LIMIT_WIDTH-1:0] COUNT_LIMIT_RESET = 10'd1023;

   // Step requests of one encoder as seen in the current item, before clearing.
   typedef struct packed {
      logic up;
      logic down;
      logic rest;
   } step_req_type;

   // Result item, count in the lowest bits.
   typedef struct packed {
      logic                       right_at_rest;
      logic                       left_at_rest;
      logic [OUT_COUNT_WIDTH-1:0] count;
   } rsp_item_type;

endpackage

@@ design/dedc_phase_tracker.sv @@
module dedc_phase_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          phase,
   output dedc_pkg::step_req_type req
);
   import dedc_pkg::*;

   logic [1:0] last_phase_ff;
   logic       up_ff;
   logic       down_ff;
   logic       up_in;
   logic       down_in;
   logic       rest;
   logic       up_seen;
   logic       down_seen;

   always_comb begin
      rest = (phase == REST_PHASE);
      down_seen = ((phase == 2'd1) && (last_phase_ff == 2'd3)) ||
                  ((phase == 2'd0) && (last_phase_ff == 2'd1)) ||
                  ((phase == 2'd2) && (last_phase_ff == 2'd0));
      up_seen   = ((phase == 2'd2) && (last_phase_ff == 2'd3)) ||
                  ((phase == 2'd0) && (last_phase_ff == 2'd2)) ||
                  ((phase == 2'd1) && (last_phase_ff == 2'd0));
      req.rest = rest;
      req.up   = up_ff   | (!rest & up_seen);
      req.down = down_ff | (!rest & down_seen);
      // A request is consumed in the item that finds the encoder at rest.
      up_in   = rest ? 1'b0 : req.up;
      down_in = rest ? 1'b0 : req.down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= 2'd0;
         up_ff         <= 1'b0;
         down_ff       <= 1'b0;
      end else if (accept) begin
         last_phase_ff <= phase;
         up_ff         <= up_in;
         down_ff       <= down_in;
      end
   end

endmodule

@@ design/dedc_count_update.sv @@
module dedc_count_update #(
   parameter int COUNT_WIDTH = dedc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  dedc_pkg::step_req_type                right_req,
   input  dedc_pkg::step_req_type                left_req,
   input  logic [dedc_pkg::STEP_WIDTH-1:0]       right_step,
   input  logic [dedc_pkg::STEP_WIDTH-1:0]       left_step,
   input  logic [dedc_pkg::LIMIT_WIDTH-1:0]      count_limit,
   output logic [COUNT_WIDTH-1:0]                count_next
);
   import dedc_pkg::*;

   localparam int LW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] limit;
   logic [LW-1:0]          limit_wide;
   logic [LW-1:0]          mask_wide;
   logic [COUNT_WIDTH-1:0] c1;
   logic [COUNT_WIDTH-1:0] c2;
   logic [COUNT_WIDTH-1:0] c3;

   function automatic logic [COUNT_WIDTH-1:0] step_up(
      input logic [COUNT_WIDTH-1:0] value,
      input logic [STEP_WIDTH-1:0]  step,
      input logic [COUNT_WIDTH-1:0] lim
   );
      logic [COUNT_WIDTH:0] sum;
      sum = (COUNT_WIDTH+1)'(value) + (COUNT_WIDTH+1)'(step);
      return (sum > (COUNT_WIDTH+1)'(lim)) ? '0 : sum[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] step_down(
      input logic [COUNT_WIDTH-1:0] value,
      input logic [STEP_WIDTH-1:0]  step,
      input logic [COUNT_WIDTH-1:0] lim
   );
      logic [COUNT_WIDTH-1:0] step_ext;
      step_ext = COUNT_WIDTH'(step);
      return (step_ext > value) ? lim : value - step_ext;
   endfunction

   always_comb begin
      limit_wide = LW'(count_limit);
      mask_wide  = LW'({COUNT_WIDTH{1'b1}});
      limit = (limit_wide > mask_wide) ? COUNT_WIDTH'(mask_wide)
                                       : COUNT_WIDTH'(limit_wide);

      // Right encoder first, then left; up before down within one encoder.
      c1 = (right_req.rest && right_req.up)   ? step_up(count_ff, right_step, limit) : count_ff;
      c2 = (right_req.rest && right_req.down) ? step_down(c1, right_step, limit)     : c1;
      c3 = (left_req.rest && left_req.up)     ? step_up(c2, left_step, limit)        : c2;
      count_next = (left_req.rest && left_req.down) ? step_down(c3, left_step, limit) : c3;
      count_in = accept ? count_next : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ design/dedc_out_buf.sv @@
module dedc_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dedc_pkg::rsp_item_type push_item,
   output logic                   push_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dedc_pkg::rsp_item_type out_item
);
   import dedc_pkg::*;

   logic         main_valid_ff;
   logic         main_valid_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_item_type main_item_ff;
   rsp_item_type main_item_in;
   rsp_item_type skid_item_ff;
   rsp_item_type skid_item_in;
   logic         pop;

   always_comb begin
      pop           = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_item_in  = main_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end else begin
            main_item_in  = push_item;
            main_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
      push_ready = !skid_valid_ff;
      out_valid  = main_valid_ff;
      out_item   = main_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

@@ design/dual_encoder_detent_counter.sv @@
// A result item is registered into the output buffer when its input is accepted.
// One item per cycle unless the buffer is full; the count loops in one register.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (synchronous, active high) clears the count, the phase history, the
// pending requests and the output buffer, and restores the register defaults.
module dual_encoder_detent_counter #(
   parameter int COUNT_WIDTH = dedc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [1:0] left_phase, [3:2] right_phase, [7:4] zero
   input  logic [dedc_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [9:0] count, [10] left_at_rest, [11] right_at_rest, [15:12] zero
   output logic [dedc_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dedc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dedc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import dedc_pkg::*;

   logic [STEP_WIDTH-1:0]  right_step_ff;
   logic [STEP_WIDTH-1:0]  left_step_ff;
   logic [LIMIT_WIDTH-1:0] count_limit_ff;
   logic                   accept;
   step_req_type           left_req;
   step_req_type           right_req;
   logic [COUNT_WIDTH-1:0] count_next;
   rsp_item_type           result;
   rsp_item_type           out_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_step_ff  <= RIGHT_STEP_RESET;
         left_step_ff   <= LEFT_STEP_RESET;
         count_limit_ff <= COUNT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RIGHT_STEP:  right_step_ff  <= csr_wdata[STEP_WIDTH-1:0];
            CSR_LEFT_STEP:   left_step_ff   <= csr_wdata[STEP_WIDTH-1:0];
            CSR_COUNT_LIMIT: count_limit_ff <= csr_wdata[LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   dedc_phase_tracker u_left (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .phase  (req_tdata[1:0]),
      .req    (left_req)
   );

   dedc_phase_tracker u_right (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .phase  (req_tdata[3:2]),
      .req    (right_req)
   );

   dedc_count_update #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .right_req   (right_req),
      .left_req    (left_req),
      .right_step  (right_step_ff),
      .left_step   (left_step_ff),
      .count_limit (count_limit_ff),
      .count_next  (count_next)
   );

   always_comb begin
      result.count         = OUT_COUNT_WIDTH'(count_next);
      result.left_at_rest  = left_req.rest;
      result.right_at_rest = right_req.rest;
   end

   dedc_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(out_item);

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("buffer not empty after reset");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled while no result is offered");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && !rsp_tvalid) |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_left_rest_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !rsp_tvalid && (req_tdata[1:0] == REST_PHASE)) |=> rsp_tdata[10])
      else $error("left rest phase not reported");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import dedc_pkg::*;

   localparam int CLOCK_LIMIT = 200000;
   localparam int RESET_CYCLES = 11;
   localparam int CONFIG_ROUNDS = 7;
   localparam int ITEMS_PER_ROUND = 200;
   localparam int QUIET_ROUND = 2;
   localparam int HOLD_AT_ITEM = 300;
   localparam int HOLD_CYCLES = 60;
   localparam int GAP_PERCENT = 13;
   localparam int DRAIN_CYCLES = 4;
   localparam int LEFT = 0;
   localparam int RIGHT = 1;
   localparam int PICK_RANDOM = -1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [1:0] left;
      logic [1:0] right;
      logic       fixed;
      logic [9:0] count;
      logic       left_rest;
      logic       right_rest;
   } tick_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam tick_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{3, 3, 1, 0, 1, 1},
      '{3, 1, 1, 0, 1, 0},
      '{3, 3, 1, 1023, 1, 1},
      '{3, 2, 1, 1023, 1, 0},
      '{3, 3, 1, 0, 1, 1},
      '{2, 3, 0, 0, 0, 0},
      '{0, 3, 0, 0, 0, 0},
      '{1, 3, 0, 0, 0, 0},
      '{3, 3, 0, 0, 0, 0},
      '{1, 3, 0, 0, 0, 0},
      '{0, 3, 0, 0, 0, 0},
      '{1, 3, 0, 0, 0, 0},
      '{3, 3, 0, 0, 0, 0},
      '{3, 1, 0, 0, 0, 0},
      '{3, 0, 0, 0, 0, 0},
      '{3, 2, 0, 0, 0, 0},
      '{3, 3, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{2, 2, 0, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0},
      '{3, 3, 0, 0, 0, 0},
      '{2, 1, 0, 0, 0, 0},
      '{3, 3, 0, 0, 0, 0}
   };

   localparam int ROUND_CONFIG [CONFIG_ROUNDS][3] = '{
      '{0, 15, 1023},
      '{15, 0, 0},
      '{7, 9, 1023},
      '{3, 1, 10},
      '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM},
      '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM},
      '{15, 15, 1023}
   };

   localparam logic [1:0] DETENT_CYCLE [4] = '{2'd3, 2'd1, 2'd0, 2'd2};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic no_gaps = 1'b0;
   logic hold_off = 1'b0;

   logic [STEP_WIDTH-1:0] cfg_right_step = RIGHT_STEP_RESET;
   logic [STEP_WIDTH-1:0] cfg_left_step = LEFT_STEP_RESET;
   logic [LIMIT_WIDTH-1:0] cfg_limit = COUNT_LIMIT_RESET;
   logic [1:0] enc_last [2] = '{2'd0, 2'd0};
   logic enc_up [2] = '{1'b0, 1'b0};
   logic enc_down [2] = '{1'b0, 1'b0};
   logic enc_rest [2] = '{1'b0, 1'b0};
   logic [OUT_COUNT_WIDTH-1:0] model_count = '0;

   int walk_pos [2] = '{0, 0};
   int walk_dir [2] = '{1, 1};

   rsp_item_type due_readings [$];

   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int reg_writes = 0;
   int wraps_up = 0;
   int wraps_down = 0;
   int cycle_count = 0;

   dual_encoder_detent_counter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void latch_phase(int e, logic [1:0] now);
      logic [1:0] prev;
      prev = enc_last[e];
      if (now != REST_PHASE) begin
         enc_rest[e] = 1'b0;
         if ((now == 2'd1 && prev == 2'd3) || (now == 2'd0 && prev == 2'd1) ||
             (now == 2'd2 && prev == 2'd0))
            enc_down[e] = 1'b1;
         if ((now == 2'd2 && prev == 2'd3) || (now == 2'd0 && prev == 2'd2) ||
             (now == 2'd1 && prev == 2'd0))
            enc_up[e] = 1'b1;
      end else begin
         enc_rest[e] = 1'b1;
      end
      enc_last[e] = now;
   endfunction

   function automatic void apply_detent(int e, logic [STEP_WIDTH-1:0] step);
      int sum;
      if (enc_rest[e]) begin
         if (enc_up[e]) begin
            sum = int'(model_count) + int'(step);
            if (sum > int'(cfg_limit)) begin
               model_count = '0;
               wraps_up++;
            end else begin
               model_count = sum[OUT_COUNT_WIDTH-1:0];
            end
            enc_up[e] = 1'b0;
         end
         if (enc_down[e]) begin
            if (int'(step) > int'(model_count)) begin
               model_count = cfg_limit;
               wraps_down++;
            end else begin
               model_count = model_count - step;
            end
            enc_down[e] = 1'b0;
         end
      end
   endfunction

   function automatic rsp_item_type next_reading(logic [1:0] lp, logic [1:0] rp);
      rsp_item_type r;
      latch_phase(LEFT, lp);
      latch_phase(RIGHT, rp);
      apply_detent(RIGHT, cfg_right_step);
      apply_detent(LEFT, cfg_left_step);
      r.count = model_count;
      r.left_at_rest = enc_rest[LEFT];
      r.right_at_rest = enc_rest[RIGHT];
      return r;
   endfunction

   // Mostly walks real detent cycles in either direction, with dwell, reversals and noise.
   function automatic logic [1:0] wander(int e);
      int roll;
      int i;
      logic [1:0] p;
      roll = $urandom_range(0, 99);
      if (walk_pos[e] == 0 && roll < 50)
         walk_dir[e] = ($urandom_range(0, 1) == 1) ? 1 : 3;
      if (roll < 45) begin
         walk_pos[e] = (walk_pos[e] + walk_dir[e]) % 4;
      end else if (roll >= 75 && roll < 85) begin
         walk_dir[e] = 4 - walk_dir[e];
         walk_pos[e] = (walk_pos[e] + walk_dir[e]) % 4;
      end else if (roll >= 85) begin
         p = 2'($urandom_range(0, 3));
         for (i = 0; i < 4; i++)
            if (DETENT_CYCLE[i] == p)
               walk_pos[e] = i;
      end
      return DETENT_CYCLE[walk_pos[e]];
   endfunction

   task automatic send_tick(logic [1:0] lp, logic [1:0] rp, logic fixed,
                            rsp_item_type fixed_reading);
      rsp_item_type want;
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'b0000, rp, lp};
      do @(posedge clock); while (!req_tready);
      want = next_reading(lp, rp);
      if (fixed)
         want = fixed_reading;
      due_readings.push_back(want);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (due_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RIGHT_STEP: cfg_right_step = value[STEP_WIDTH-1:0];
         CSR_LEFT_STEP: cfg_left_step = value[STEP_WIDTH-1:0];
         CSR_COUNT_LIMIT: cfg_limit = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= !hold_off && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT);

   initial begin
      wait (items_sent >= HOLD_AT_ITEM);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         if (due_readings.size() == 0) begin
            $error("result item with no expectation: count %0d", got.count);
            failures++;
         end else begin
            want = due_readings.pop_front();
            results_seen++;
            if (got.count !== want.count) begin
               $error("count expected %0d actual %0d", want.count, got.count);
               failures++;
            end
            if (got.left_at_rest !== want.left_at_rest) begin
               $error("left_at_rest expected %0d actual %0d",
                      want.left_at_rest, got.left_at_rest);
               failures++;
            end
            if (got.right_at_rest !== want.right_at_rest) begin
               $error("right_at_rest expected %0d actual %0d",
                      want.right_at_rest, got.right_at_rest);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int row;
      int round;
      int k;
      rsp_item_type typed;
      logic [CSR_DATA_WIDTH-1:0] value;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         typed.count = DIRECTED[row].count;
         typed.left_at_rest = DIRECTED[row].left_rest;
         typed.right_at_rest = DIRECTED[row].right_rest;
         send_tick(DIRECTED[row].left, DIRECTED[row].right, DIRECTED[row].fixed, typed);
      end

      for (round = 0; round < CONFIG_ROUNDS; round++) begin
         settle();
         write_register(CSR_UNMAPPED, CSR_DATA_WIDTH'($urandom_range(0, 1023)));
         value = (ROUND_CONFIG[round][0] == PICK_RANDOM) ?
                 CSR_DATA_WIDTH'($urandom_range(0, 15)) :
                 CSR_DATA_WIDTH'(ROUND_CONFIG[round][0]);
         write_register(CSR_RIGHT_STEP, value);
         value = (ROUND_CONFIG[round][1] == PICK_RANDOM) ?
                 CSR_DATA_WIDTH'($urandom_range(0, 15)) :
                 CSR_DATA_WIDTH'(ROUND_CONFIG[round][1]);
         write_register(CSR_LEFT_STEP, value);
         value = (ROUND_CONFIG[round][2] == PICK_RANDOM) ?
                 CSR_DATA_WIDTH'($urandom_range(0, 1023)) :
                 CSR_DATA_WIDTH'(ROUND_CONFIG[round][2]);
         write_register(CSR_COUNT_LIMIT, value);
         @(posedge clock);
         no_gaps = (round == QUIET_ROUND);
         for (k = 0; k < ITEMS_PER_ROUND; k++)
            send_tick(wander(LEFT), wander(RIGHT), 1'b0, '0);
      end
      settle();

      if (due_readings.size() != 0) begin
         $error("%0d expected result items never arrived", due_readings.size());
         failures++;
      end

      $display("Sent %0d encoder items and checked %0d results across %0d register writes.",
               items_sent, results_seen, reg_writes);
      $display("The count wrapped past the limit %0d times and below zero %0d times.",
               wraps_up, wraps_down);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
